[sv/bcd_calendar_tick_macros.svh]
// Assertion macros used by the calendar top level.
`ifndef BCD_CALENDAR_TICK_MACROS_SVH
`define BCD_CALENDAR_TICK_MACROS_SVH

// Checked only out of reset.
`define BCDC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define BCDC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/bcdc_pkg.sv]
// Package: field widths, cell settings and shared types of the BCD calendar.
package bcdc_pkg;

  localparam int CELL_W     = 8;
  localparam int NUM_CELLS  = 6;
  localparam int YEAR_W     = 8;
  localparam int MONTH_W    = 5;
  localparam int DAY_W      = 6;
  localparam int HOUR_W     = 6;
  localparam int MINUTE_W   = 7;
  localparam int SECOND_W   = 7;

  // position in the carry chain, least significant first
  localparam int IDX_SECOND = 0;
  localparam int IDX_MINUTE = 1;
  localparam int IDX_HOUR   = 2;
  localparam int IDX_DAY    = 3;
  localparam int IDX_MONTH  = 4;
  localparam int IDX_YEAR   = 5;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [CELL_W-1:0] mask;   // field width
    logic [CELL_W-1:0] limit;  // value that rolls over
    logic [CELL_W-1:0] wrap;   // value after rollover
    logic [CELL_W-1:0] init;   // value after reset
  } cell_cfg_t;

  typedef cell_cfg_t [NUM_CELLS-1:0] cell_cfg_row_t;

  localparam cell_cfg_row_t CELL_CFG = '{
    // year, month, day (limit set at run time), hour, minute, second
    '{mask: 8'hFF, limit: 8'hA0, wrap: 8'h00, init: 8'h00},
    '{mask: 8'h1F, limit: 8'h13, wrap: 8'h01, init: 8'h01},
    '{mask: 8'h3F, limit: 8'h31, wrap: 8'h01, init: 8'h01},
    '{mask: 8'h3F, limit: 8'h24, wrap: 8'h00, init: 8'h00},
    '{mask: 8'h7F, limit: 8'h60, wrap: 8'h00, init: 8'h00},
    '{mask: 8'h7F, limit: 8'h60, wrap: 8'h00, init: 8'h00}
  };

  // year value mod 4 == 0, i.e. (2*tens + units) mod 4 == 0
  function automatic logic year_is_leap(input logic [YEAR_W-1:0] year);
    return (year[0] == 1'b0) && (year[1] == year[4]);
  endfunction

endpackage

[sv/bcdc_if.sv]
// Channel interfaces: command words in, calendar words out.
interface bcdc_cmd_if;
  import bcdc_pkg::*;

  logic                valid;
  logic                ready;
  opcode_t             opcode;
  logic [YEAR_W-1:0]   set_year;
  logic [MONTH_W-1:0]  set_month;
  logic [DAY_W-1:0]    set_day;
  logic [HOUR_W-1:0]   set_hour;
  logic [MINUTE_W-1:0] set_minute;
  logic [SECOND_W-1:0] set_second;

  modport source (output valid, opcode, set_year, set_month, set_day, set_hour,
                  set_minute, set_second, input ready);
  modport sink   (input valid, opcode, set_year, set_month, set_day, set_hour,
                  set_minute, set_second, output ready);
endinterface

interface bcdc_res_if;
  import bcdc_pkg::*;

  logic                valid;
  logic                ready;
  logic [YEAR_W-1:0]   year_out;
  logic [MONTH_W-1:0]  month_out;
  logic [DAY_W-1:0]    day_out;
  logic [HOUR_W-1:0]   hour_out;
  logic [MINUTE_W-1:0] minute_out;
  logic [SECOND_W-1:0] second_out;

  modport source (output valid, year_out, month_out, day_out, hour_out,
                  minute_out, second_out, input ready);
  modport sink   (input valid, year_out, month_out, day_out, hour_out,
                  minute_out, second_out, output ready);
endinterface

[sv/bcd_calendar_tick.sv]
// Top level: BCD real-time clock and calendar driven by tick and load words.
//
// Takes one command word per cycle and returns one calendar word for each: the
// year, month, day, hour, minute and second in packed BCD after the tick or load.
// A chain of six counter cells, second to year, ripples the carry within the
// cycle, so a result appears in the cycle after its command is taken and a new
// command is taken every cycle while the result side is not stalled. The state
// itself is the output word; a stalled result holds the command side off. Leap
// years are those whose value divides by 4; year 99 wraps to 00. After reset the
// calendar reads 00-01-01 00:00:00.
module bcd_calendar_tick (
  input logic        clk,
  input logic        rst,
  bcdc_cmd_if.sink   cmd,
  bcdc_res_if.source res
);
  import bcdc_pkg::*;

  `include "bcd_calendar_tick_macros.svh"

  logic                             cmd_take;
  logic                             load;
  logic                             res_valid;
  logic [YEAR_W-1:0]                year_q;
  logic [MONTH_W-1:0]               month_q;
  logic [CELL_W-1:0]                day_limit;
  cell_cfg_row_t                    cfg;
  logic [NUM_CELLS-1:0][CELL_W-1:0] load_value;
  logic [NUM_CELLS-1:0][CELL_W-1:0] value;
  logic [NUM_CELLS:0]               carry;

  assign cmd.ready = !res_valid || res.ready;
  assign cmd_take  = cmd.valid && cmd.ready;
  assign load      = cmd_take && (cmd.opcode == OP_LOAD);
  assign carry[0]  = cmd_take && (cmd.opcode == OP_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.ready) begin
      res_valid <= cmd.valid;
    end
  end

  assign year_q  = value[IDX_YEAR][YEAR_W-1:0];
  assign month_q = value[IDX_MONTH][MONTH_W-1:0];

  // day that rolls over into the next month
  always_comb begin
    if (month_q inside {5'h01, 5'h03, 5'h05, 5'h07, 5'h08, 5'h10, 5'h12}) begin
      day_limit = 8'h32;
    end else if (month_q == 5'h02) begin
      day_limit = year_is_leap(year_q) ? 8'h30 : 8'h29;
    end else begin
      day_limit = 8'h31;
    end
  end

  always_comb begin
    cfg                  = CELL_CFG;
    cfg[IDX_DAY].limit   = day_limit;
    load_value[IDX_SECOND] = CELL_W'(cmd.set_second);
    load_value[IDX_MINUTE] = CELL_W'(cmd.set_minute);
    load_value[IDX_HOUR]   = CELL_W'(cmd.set_hour);
    load_value[IDX_DAY]    = CELL_W'(cmd.set_day);
    load_value[IDX_MONTH]  = CELL_W'(cmd.set_month);
    load_value[IDX_YEAR]   = CELL_W'(cmd.set_year);
  end

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    bcdc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cfg        (cfg[k]),
      .load       (load),
      .load_value (load_value[k]),
      .carry_in   (carry[k]),
      .value      (value[k]),
      .carry_out  (carry[k+1])
    );
  end

  assign res.valid      = res_valid;
  assign res.year_out   = year_q;
  assign res.month_out  = month_q;
  assign res.day_out    = value[IDX_DAY][DAY_W-1:0];
  assign res.hour_out   = value[IDX_HOUR][HOUR_W-1:0];
  assign res.minute_out = value[IDX_MINUTE][MINUTE_W-1:0];
  assign res.second_out = value[IDX_SECOND][SECOND_W-1:0];

  `BCDC_ASSERT_ALWAYS(a_no_word_after_reset, rst |=> !res.valid, "result word after reset")
  `BCDC_ASSERT(a_stall_blocks_cmd, (res.valid && !res.ready) |-> !cmd.ready, "command taken while result stalled")
  `BCDC_ASSERT(a_load_second, (cmd.valid && cmd.ready && cmd.opcode == OP_LOAD) |=> (res.second_out == $past(cmd.set_second)), "loaded second lost")
  `BCDC_ASSERT(a_no_carry_past_second, (carry[IDX_MINUTE] == 1'b0) |-> (carry[NUM_CELLS:IDX_MINUTE+1] == '0), "carry without carry from the second")

endmodule

[sv/bcdc_cell.sv]
// One BCD counter cell of the calendar chain: holds a field, passes its carry on.
module bcdc_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  bcdc_pkg::cell_cfg_t        cfg,
  input  logic                       load,
  input  logic [bcdc_pkg::CELL_W-1:0] load_value,
  input  logic                       carry_in,
  output logic [bcdc_pkg::CELL_W-1:0] value,
  output logic                       carry_out
);
  import bcdc_pkg::*;

  logic [CELL_W-1:0] inc;
  logic [CELL_W-1:0] adj;
  logic [CELL_W-1:0] value_next;

  always_comb begin
    inc       = (value + CELL_W'(1)) & cfg.mask;
    adj       = (inc[3:0] == 4'hA) ? ((inc + CELL_W'(6)) & cfg.mask) : inc;
    carry_out = carry_in && (adj == cfg.limit);
    if (load) begin
      value_next = load_value & cfg.mask;
    end else if (carry_out) begin
      value_next = cfg.wrap;
    end else if (carry_in) begin
      value_next = adj;
    end else begin
      value_next = value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= cfg.init;
    end else begin
      value <= value_next;
    end
  end

endmodule
